FILE: rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg
// shared types, constants and datapath commands of the huffman code builder
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

  localparam int MaxSymbols = 32;
  localparam int FreqBits   = 24;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusEmpty    = 2'd1;
  localparam logic [1:0] StatusOverflow = 2'd2;

  typedef struct packed {
    logic [7:0]  symbol;
    logic [23:0] frequency;
    logic        last_pair;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_symbol;
    logic [30:0] code_bits;
    logic [4:0]  code_length;
    logic [1:0]  status;
    logic        last_code;
  } out_item_t;

  typedef enum logic [4:0] {
    CmdNone,
    CmdLoad,
    CmdStart,
    CmdInit,
    CmdBuild,
    CmdSdWeight,
    CmdSdLeft,
    CmdSdLeftIdx,
    CmdSdLeftCmp,
    CmdSdRight,
    CmdSdRightIdx,
    CmdSdRightCmp,
    CmdSdFinish,
    CmdPopTop,
    CmdPopLast,
    CmdPopMove,
    CmdTakeA,
    CmdReadA,
    CmdReadB,
    CmdMerge,
    CmdUpCheck,
    CmdUpIdx,
    CmdUpCmp,
    CmdUpDone,
    CmdWalkInit,
    CmdWalkPop,
    CmdWalkRead,
    CmdWalkVisit,
    CmdWalkLeft,
    CmdWait
  } dp_cmd_e;

  typedef struct packed {
    logic in_last;
    logic empty;
    logic init_last;
    logic build_done;
    logic left_ok;
    logic right_ok;
    logic best_is_at;
    logic up_stop;
    logic up_swap;
    logic more;
    logic is_leaf;
    logic out_xfer;
    logic out_last;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/huffman_code_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_builder
// builds a huffman code table from symbol and frequency pairs
// pairs transfer one per cycle while loading; after the last pair the input
// stalls while the heap is built and merged (each level of a sift-down and
// of a sift-up is stepped through in states, set by the single read port of
// the heap and node memories) and the tree is walked (an inner node pushes
// both children, a leaf waits for its output transfer)
// reset is asynchronous active low; no memory clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder #(
  parameter int MAX_SYMBOLS = hcb_pkg::MaxSymbols,
  parameter int FREQ_BITS   = hcb_pkg::FreqBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hcb_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hcb_pkg::out_item_t out_item_o
);

  hcb_pkg::dp_cmd_e    cmd;
  hcb_pkg::dp_status_t status;

  hcb_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  hcb_datapath #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .FREQ_BITS   (FREQ_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: rtl/hcb_datapath.sv
// ----------------------------------------------------------------------------
// hcb_datapath
// node, heap and walk stack memories with the registers that work on them
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_datapath #(
  parameter int MAX_SYMBOLS = hcb_pkg::MaxSymbols,
  parameter int FREQ_BITS   = hcb_pkg::FreqBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hcb_pkg::dp_cmd_e     cmd_i,
  output hcb_pkg::dp_status_t  status_o,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hcb_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hcb_pkg::out_item_t   out_item_o
);

  localparam int NodeSlots = 2 * MAX_SYMBOLS - 1;
  localparam int IW        = $clog2(2 * MAX_SYMBOLS);
  localparam int HW        = $clog2(MAX_SYMBOLS);
  localparam int WW        = FREQ_BITS + $clog2(MAX_SYMBOLS);

  typedef logic [IW-1:0] idx_t;
  typedef struct packed {
    idx_t        node;
    logic [30:0] code;
    logic [4:0]  depth;
  } stk_t;

  logic [WW-1:0] wt_mem    [NodeSlots];
  idx_t          left_mem  [NodeSlots];
  idx_t          right_mem [NodeSlots];
  logic          leaf_mem  [NodeSlots];
  logic [7:0]    sym_mem   [MAX_SYMBOLS];
  idx_t          hp_mem    [MAX_SYMBOLS];
  stk_t          stk_mem   [MAX_SYMBOLS];

  idx_t cnt_q, ld_q, i_q, at_q, best_q, next_q, sp_q, emit_q;
  logic ovf_q, out_valid_q;
  idx_t best_n_q, cur_n_q, cand_q, top_q, a_q, par_q;
  logic [WW-1:0] cur_w_q, best_w_q, a_w_q;
  logic [30:0] path_q;
  logic [4:0]  dep_q;
  hcb_pkg::out_item_t out_q;

  logic [WW-1:0] wt_rd_q;
  idx_t          hp_rd_q, nleft_q, nright_q;
  stk_t          stk_rd_q;
  logic          nleaf_q;
  logic [7:0]    nsym_q;

  logic          in_xfer, out_xfer;
  logic [31:0]   f32;
  logic [FREQ_BITS-1:0] fval;
  logic [IW:0]   l_idx, r_idx;
  logic          l_ok, r_ok, best_is_at, up_swap, lt_best;
  idx_t          up_par, cnt_m1, ld_m1, sp_m1;
  logic [WW-1:0] sum;

  logic          wt_re, wt_we, lr_we, leaf_we, leaf_wd, sym_we;
  idx_t          wt_ra, wt_wa;
  logic [WW-1:0] wt_wd;
  logic          hp_re, hp_we;
  logic [HW-1:0] hp_ra, hp_wa;
  idx_t          hp_wd;
  logic          stk_re, stk_we, nd_re;
  logic [HW-1:0] stk_ra, stk_wa;
  stk_t          stk_wd;

  assign in_stall_o = (cmd_i != hcb_pkg::CmdLoad);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign f32        = 32'(in_item_i.frequency);
  assign fval       = f32[FREQ_BITS-1:0];
  assign l_idx      = {at_q, 1'b1};
  assign r_idx      = l_idx + (IW+1)'(1);
  assign l_ok       = l_idx < {1'b0, cnt_q};
  assign r_ok       = r_idx < {1'b0, cnt_q};
  assign best_is_at = (best_q == at_q);
  assign lt_best    = wt_rd_q < best_w_q;
  assign up_swap    = cur_w_q < wt_rd_q;
  assign up_par     = (i_q - idx_t'(1)) >> 1;
  assign cnt_m1     = cnt_q - idx_t'(1);
  assign ld_m1      = ld_q - idx_t'(1);
  assign sp_m1      = sp_q - idx_t'(1);
  assign sum        = a_w_q + wt_rd_q;

  always_comb begin
    wt_re   = 1'b0;
    wt_ra   = '0;
    wt_we   = 1'b0;
    wt_wa   = ld_q;
    wt_wd   = WW'(fval);
    lr_we   = 1'b0;
    leaf_we = 1'b0;
    leaf_wd = 1'b1;
    sym_we  = 1'b0;
    hp_re   = 1'b0;
    hp_ra   = '0;
    hp_we   = 1'b0;
    hp_wa   = '0;
    hp_wd   = '0;
    stk_re  = 1'b0;
    stk_ra  = sp_m1[HW-1:0];
    stk_we  = 1'b0;
    stk_wa  = sp_q[HW-1:0];
    stk_wd  = '0;
    nd_re   = 1'b0;
    case (cmd_i)
      hcb_pkg::CmdLoad: begin
        if (in_xfer && fval != '0 && ld_q < idx_t'(MAX_SYMBOLS)) begin
          wt_we   = 1'b1;
          leaf_we = 1'b1;
          sym_we  = 1'b1;
        end
      end
      hcb_pkg::CmdInit: begin
        hp_we = 1'b1;
        hp_wa = i_q[HW-1:0];
        hp_wd = i_q;
      end
      hcb_pkg::CmdBuild: begin
        wt_re = (i_q != '0);
        wt_ra = i_q - idx_t'(1);
      end
      hcb_pkg::CmdSdLeft: begin
        hp_re = l_ok;
        hp_ra = l_idx[HW-1:0];
      end
      hcb_pkg::CmdSdRight: begin
        hp_re = r_ok;
        hp_ra = r_idx[HW-1:0];
      end
      hcb_pkg::CmdSdLeftIdx, hcb_pkg::CmdSdRightIdx, hcb_pkg::CmdPopMove,
      hcb_pkg::CmdUpIdx: begin
        wt_re = 1'b1;
        wt_ra = hp_rd_q;
      end
      hcb_pkg::CmdSdFinish: begin
        hp_we = 1'b1;
        hp_wa = at_q[HW-1:0];
        hp_wd = best_is_at ? cur_n_q : best_n_q;
      end
      hcb_pkg::CmdPopTop: begin
        hp_re = 1'b1;
      end
      hcb_pkg::CmdPopLast: begin
        hp_re = 1'b1;
        hp_ra = cnt_m1[HW-1:0];
      end
      hcb_pkg::CmdReadA: begin
        wt_re = 1'b1;
        wt_ra = a_q;
      end
      hcb_pkg::CmdReadB: begin
        wt_re = 1'b1;
        wt_ra = top_q;
      end
      hcb_pkg::CmdMerge: begin
        wt_we   = 1'b1;
        wt_wa   = next_q;
        wt_wd   = sum;
        lr_we   = 1'b1;
        leaf_we = 1'b1;
        leaf_wd = 1'b0;
      end
      hcb_pkg::CmdUpCheck: begin
        if (i_q == '0) begin
          hp_we = 1'b1;
          hp_wd = next_q;
        end else begin
          hp_re = 1'b1;
          hp_ra = up_par[HW-1:0];
        end
      end
      hcb_pkg::CmdUpCmp: begin
        hp_we = 1'b1;
        hp_wa = i_q[HW-1:0];
        hp_wd = up_swap ? par_q : next_q;
      end
      hcb_pkg::CmdWalkInit: begin
        stk_we = 1'b1;
        stk_wa = '0;
        stk_wd = '{node: top_q, code: '0, depth: '0};
      end
      hcb_pkg::CmdWalkPop: begin
        stk_re = 1'b1;
      end
      hcb_pkg::CmdWalkRead: begin
        nd_re = 1'b1;
      end
      hcb_pkg::CmdWalkVisit: begin
        stk_we = !nleaf_q;
        stk_wd = '{node: nright_q, code: {path_q[29:0], 1'b1}, depth: dep_q + 5'd1};
      end
      hcb_pkg::CmdWalkLeft: begin
        stk_we = 1'b1;
        stk_wd = '{node: nleft_q, code: {path_q[29:0], 1'b0}, depth: dep_q + 5'd1};
      end
      default: begin
      end
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (wt_we) wt_mem[wt_wa] <= wt_wd;
    if (lr_we) begin
      left_mem[next_q]  <= a_q;
      right_mem[next_q] <= top_q;
    end
    if (leaf_we) leaf_mem[wt_wa] <= leaf_wd;
    if (sym_we) sym_mem[ld_q[HW-1:0]] <= in_item_i.symbol;
    if (hp_we) hp_mem[hp_wa] <= hp_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (wt_re) wt_rd_q <= wt_mem[wt_ra];
    if (hp_re) hp_rd_q <= hp_mem[hp_ra];
    if (stk_re) stk_rd_q <= stk_mem[stk_ra];
    if (nd_re) begin
      nleft_q  <= left_mem[stk_rd_q.node];
      nright_q <= right_mem[stk_rd_q.node];
      nleaf_q  <= leaf_mem[stk_rd_q.node];
      nsym_q   <= sym_mem[stk_rd_q.node[HW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ld_q        <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      at_q        <= '0;
      best_q      <= '0;
      next_q      <= '0;
      sp_q        <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (cmd_i)
        hcb_pkg::CmdLoad: begin
          if (in_xfer && fval != '0) begin
            if (ld_q < idx_t'(MAX_SYMBOLS)) ld_q <= ld_q + idx_t'(1);
            else ovf_q <= 1'b1;
          end
        end
        hcb_pkg::CmdStart: begin
          i_q    <= '0;
          cnt_q  <= ld_q;
          next_q <= ld_q;
          if (ld_q == '0) out_valid_q <= 1'b1;
        end
        hcb_pkg::CmdInit: begin
          if (i_q == ld_m1) i_q <= ld_q >> 1;
          else i_q <= i_q + idx_t'(1);
        end
        hcb_pkg::CmdBuild: begin
          if (i_q != '0) begin
            i_q  <= i_q - idx_t'(1);
            at_q <= i_q - idx_t'(1);
          end
        end
        hcb_pkg::CmdSdWeight: best_q <= at_q;
        hcb_pkg::CmdSdLeftCmp: if (lt_best) best_q <= l_idx[IW-1:0];
        hcb_pkg::CmdSdRightCmp: if (lt_best) best_q <= r_idx[IW-1:0];
        hcb_pkg::CmdSdFinish: at_q <= best_q;
        hcb_pkg::CmdPopMove: begin
          cnt_q <= cnt_m1;
          at_q  <= '0;
        end
        hcb_pkg::CmdMerge: begin
          i_q   <= cnt_q;
          cnt_q <= cnt_q + idx_t'(1);
        end
        hcb_pkg::CmdUpCmp: if (up_swap) i_q <= up_par;
        hcb_pkg::CmdUpDone: next_q <= next_q + idx_t'(1);
        hcb_pkg::CmdWalkInit: begin
          sp_q   <= idx_t'(1);
          emit_q <= '0;
        end
        hcb_pkg::CmdWalkPop: sp_q <= sp_m1;
        hcb_pkg::CmdWalkVisit: begin
          if (nleaf_q) begin
            out_valid_q <= 1'b1;
            emit_q      <= emit_q + idx_t'(1);
          end else begin
            sp_q <= sp_q + idx_t'(1);
          end
        end
        hcb_pkg::CmdWalkLeft: sp_q <= sp_q + idx_t'(1);
        hcb_pkg::CmdWait: begin
          if (out_xfer) begin
            out_valid_q <= 1'b0;
            if (out_q.last_code) begin
              cnt_q <= '0;
              ld_q  <= '0;
              ovf_q <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working values and result payload
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      hcb_pkg::CmdStart: begin
        out_q <= '{out_symbol: '0, code_bits: '0, code_length: '0,
                   status: hcb_pkg::StatusEmpty, last_code: 1'b1};
      end
      hcb_pkg::CmdBuild: cur_n_q <= i_q - idx_t'(1);
      hcb_pkg::CmdSdWeight: begin
        cur_w_q  <= wt_rd_q;
        best_w_q <= wt_rd_q;
      end
      hcb_pkg::CmdSdLeftIdx, hcb_pkg::CmdSdRightIdx: cand_q <= hp_rd_q;
      hcb_pkg::CmdSdLeftCmp, hcb_pkg::CmdSdRightCmp: begin
        if (lt_best) begin
          best_n_q <= cand_q;
          best_w_q <= wt_rd_q;
        end
      end
      hcb_pkg::CmdSdFinish: best_w_q <= cur_w_q;
      hcb_pkg::CmdPopLast: top_q <= hp_rd_q;
      hcb_pkg::CmdPopMove: cur_n_q <= hp_rd_q;
      hcb_pkg::CmdTakeA: a_q <= top_q;
      hcb_pkg::CmdReadB: a_w_q <= wt_rd_q;
      hcb_pkg::CmdMerge: cur_w_q <= sum;
      hcb_pkg::CmdUpIdx: par_q <= hp_rd_q;
      hcb_pkg::CmdWalkRead: begin
        path_q <= stk_rd_q.code;
        dep_q  <= stk_rd_q.depth;
      end
      hcb_pkg::CmdWalkVisit: begin
        if (nleaf_q) begin
          out_q <= '{out_symbol: nsym_q, code_bits: path_q, code_length: dep_q,
                     status: ovf_q ? hcb_pkg::StatusOverflow : hcb_pkg::StatusOk,
                     last_code: (emit_q == ld_m1)};
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign status_o = '{
    in_last:    in_xfer && in_item_i.last_pair,
    empty:      (ld_q == '0),
    init_last:  (i_q == ld_m1),
    build_done: (i_q == '0),
    left_ok:    l_ok,
    right_ok:   r_ok,
    best_is_at: best_is_at,
    up_stop:    (i_q == '0),
    up_swap:    up_swap,
    more:       (cnt_q > idx_t'(1)),
    is_leaf:    nleaf_q,
    out_xfer:   out_xfer,
    out_last:   out_q.last_code
  };

endmodule

`default_nettype wire

FILE: rtl/hcb_controller.sv
// ----------------------------------------------------------------------------
// hcb_controller
// sequencer for load, heap build, merge loop and tree walk
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcb_pkg::dp_status_t status_i,
  output hcb_pkg::dp_cmd_e    cmd_o
);

  typedef enum logic [4:0] {
    SLoad, SStart, SInit, SBuild, SSdW, SSdL, SSdL1, SSdL2, SSdR, SSdR1, SSdR2,
    SSdFin, SP0, SP1, SP2, SMsel, STakeA, SRdA, SRdB, SMerge, SU0, SU1, SU2,
    SUDone, SW0, SW1, SW2, SW3, SW4, SWait
  } state_e;

  state_e state_q, ret_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad;
      ret_q   <= SLoad;
    end else begin
      case (state_q)
        SLoad:   if (status_i.in_last) state_q <= SStart;
        SStart:  state_q <= status_i.empty ? SWait : SInit;
        SInit:   if (status_i.init_last) state_q <= SBuild;
        SBuild: begin
          if (status_i.build_done) begin
            state_q <= SMsel;
          end else begin
            ret_q   <= SBuild;
            state_q <= SSdW;
          end
        end
        SSdW:    state_q <= SSdL;
        SSdL:    state_q <= status_i.left_ok ? SSdL1 : SSdFin;
        SSdL1:   state_q <= SSdL2;
        SSdL2:   state_q <= SSdR;
        SSdR:    state_q <= status_i.right_ok ? SSdR1 : SSdFin;
        SSdR1:   state_q <= SSdR2;
        SSdR2:   state_q <= SSdFin;
        SSdFin:  state_q <= status_i.best_is_at ? ret_q : SSdL;
        SMsel: begin
          ret_q   <= status_i.more ? STakeA : SW0;
          state_q <= SP0;
        end
        SP0:     state_q <= SP1;
        SP1:     state_q <= SP2;
        SP2:     state_q <= SSdW;
        STakeA: begin
          ret_q   <= SRdA;
          state_q <= SP0;
        end
        SRdA:    state_q <= SRdB;
        SRdB:    state_q <= SMerge;
        SMerge:  state_q <= SU0;
        SU0:     state_q <= status_i.up_stop ? SUDone : SU1;
        SU1:     state_q <= SU2;
        SU2:     state_q <= status_i.up_swap ? SU0 : SUDone;
        SUDone:  state_q <= SMsel;
        SW0:     state_q <= SW1;
        SW1:     state_q <= SW2;
        SW2:     state_q <= SW3;
        SW3:     state_q <= status_i.is_leaf ? SWait : SW4;
        SW4:     state_q <= SW1;
        SWait: begin
          if (status_i.out_xfer) state_q <= status_i.out_last ? SLoad : SW1;
        end
        default: state_q <= SLoad;
      endcase
    end
  end

  always_comb begin
    case (state_q)
      SLoad:   cmd_o = hcb_pkg::CmdLoad;
      SStart:  cmd_o = hcb_pkg::CmdStart;
      SInit:   cmd_o = hcb_pkg::CmdInit;
      SBuild:  cmd_o = hcb_pkg::CmdBuild;
      SSdW:    cmd_o = hcb_pkg::CmdSdWeight;
      SSdL:    cmd_o = hcb_pkg::CmdSdLeft;
      SSdL1:   cmd_o = hcb_pkg::CmdSdLeftIdx;
      SSdL2:   cmd_o = hcb_pkg::CmdSdLeftCmp;
      SSdR:    cmd_o = hcb_pkg::CmdSdRight;
      SSdR1:   cmd_o = hcb_pkg::CmdSdRightIdx;
      SSdR2:   cmd_o = hcb_pkg::CmdSdRightCmp;
      SSdFin:  cmd_o = hcb_pkg::CmdSdFinish;
      SP0:     cmd_o = hcb_pkg::CmdPopTop;
      SP1:     cmd_o = hcb_pkg::CmdPopLast;
      SP2:     cmd_o = hcb_pkg::CmdPopMove;
      STakeA:  cmd_o = hcb_pkg::CmdTakeA;
      SRdA:    cmd_o = hcb_pkg::CmdReadA;
      SRdB:    cmd_o = hcb_pkg::CmdReadB;
      SMerge:  cmd_o = hcb_pkg::CmdMerge;
      SU0:     cmd_o = hcb_pkg::CmdUpCheck;
      SU1:     cmd_o = hcb_pkg::CmdUpIdx;
      SU2:     cmd_o = hcb_pkg::CmdUpCmp;
      SUDone:  cmd_o = hcb_pkg::CmdUpDone;
      SW0:     cmd_o = hcb_pkg::CmdWalkInit;
      SW1:     cmd_o = hcb_pkg::CmdWalkPop;
      SW2:     cmd_o = hcb_pkg::CmdWalkRead;
      SW3:     cmd_o = hcb_pkg::CmdWalkVisit;
      SW4:     cmd_o = hcb_pkg::CmdWalkLeft;
      SWait:   cmd_o = hcb_pkg::CmdWait;
      default: cmd_o = hcb_pkg::CmdNone;
    endcase
  end

endmodule

`default_nettype wire
